// ----- design/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants for the complementary pitch filter
// Fixed-point formats, arithmetic table, command and status structs.
// ----------------------------------------------------------------------------
package cfp_pkg;

   // Algorithm constants
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 16;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int ACCEL_W = 16;
   localparam int GYRO_W  = 20;
   localparam int PITCH_W = 32;
   localparam int CFG_W   = 16;
   localparam int ALPHA_W = 16;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_ALPHA = 2'd1;
   localparam logic [CFG_W-1:0] SAMPLE_TIME_RESET = 16'd10;
   localparam logic [CFG_W-1:0] BLEND_ALPHA_RESET = 16'd64225;

   // CORDIC: x, y and z (Q24 degrees) registers
   localparam int CORDIC_W  = 36;
   localparam int ACC_SHIFT = 16;
   localparam int Z_FRAC    = 24;
   localparam int ROUND_SH  = Z_FRAC - ANGLE_FRAC_BITS;
   localparam int ATAN_W    = 31;
   localparam int ATAN_IDX_W = 5;
   localparam logic signed [CORDIC_W-1:0] Z_PLUS_180  = 36'sd3019898880;
   localparam logic signed [CORDIC_W-1:0] Z_MINUS_180 = -36'sd3019898880;

   // Gyro step: |gx| * dt << GSH, then divided by 1000 with rounding
   localparam int MAG_W     = GYRO_W;
   localparam int PROD_W    = MAG_W + TIME_W;
   localparam int GSH       = ANGLE_FRAC_BITS - 8;
   localparam int NUM_W     = PROD_W + GSH + 1;
   localparam int DIV_BITS  = 4;
   localparam int DIV_CYCLES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_PAD_W = DIV_CYCLES * DIV_BITS;
   localparam int REM_W     = 10;
   localparam int DIVISOR   = 1000;
   localparam int ROUND_ADD = DIVISOR / 2;
   localparam int GSTEP_W   = DIV_PAD_W + 2;

   // Shared multiplier and blend
   localparam int MUL_W   = TIME_W + 1;
   localparam int MPROD_W = 2 * MUL_W;
   localparam int BLEND_W = MPROD_W + 2;
   localparam int SAT_W   = (GSTEP_W > BLEND_W) ? GSTEP_W : BLEND_W;

   // Iteration phase covers both CORDIC and divider
   localparam int ITER_CYCLES = (CORDIC_STEPS > DIV_CYCLES) ? CORDIC_STEPS : DIV_CYCLES;
   localparam int ITER_IDX_W  = $clog2(ITER_CYCLES);

   // Multiplier operand selection
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_SEL_DT    = 2'd0;
   localparam mul_sel_type MUL_SEL_ALPHA = 2'd1;
   localparam mul_sel_type MUL_SEL_BETA  = 2'd2;

   typedef struct packed {
      logic                  take;
      logic                  take_upd;
      logic                  mul_en;
      mul_sel_type           mul_sel;
      logic                  load;
      logic                  iter_en;
      logic [ITER_IDX_W-1:0] iter_idx;
      logic                  finish;
      logic                  first;
      logic                  sum_cap;
      logic                  blend;
      logic                  out_load;
   } cfp_cmd_type;

   typedef struct packed {
      logic started;
      logic dt_ok;
   } cfp_status_type;

   // round(atan(2^-k) * 180 / pi * 2^24)
   function automatic logic [ATAN_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] k);
      logic [ATAN_W-1:0] t;
      unique case (k)
         5'd0:  t = 31'd754974720;
         5'd1:  t = 31'd445687602;
         5'd2:  t = 31'd235489088;
         5'd3:  t = 31'd119537938;
         5'd4:  t = 31'd60000934;
         5'd5:  t = 31'd30029717;
         5'd6:  t = 31'd15018523;
         5'd7:  t = 31'd7509720;
         5'd8:  t = 31'd3754917;
         5'd9:  t = 31'd1877466;
         5'd10: t = 31'd938734;
         5'd11: t = 31'd469367;
         5'd12: t = 31'd234684;
         5'd13: t = 31'd117342;
         5'd14: t = 31'd58671;
         5'd15: t = 31'd29335;
         5'd16: t = 31'd14668;
         5'd17: t = 31'd7334;
         5'd18: t = 31'd3667;
         5'd19: t = 31'd1833;
         5'd20: t = 31'd917;
         5'd21: t = 31'd458;
         5'd22: t = 31'd229;
         5'd23: t = 31'd115;
         5'd24: t = 31'd57;
         5'd25: t = 31'd29;
         5'd26: t = 31'd14;
         5'd27: t = 31'd7;
         5'd28: t = 31'd4;
         5'd29: t = 31'd2;
         5'd30: t = 31'd1;
         default: t = 31'd0;
      endcase
      return t;
   endfunction

   // Clip a wide signed value to the pitch range
   function automatic logic signed [PITCH_W-1:0] sat_pitch(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-PITCH_W:0] hi;
      logic signed [PITCH_W-1:0] r;
      hi = v[SAT_W-1:PITCH_W-1];
      if ((&hi) || !(|hi)) begin
         r = v[PITCH_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(PITCH_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(PITCH_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- design/cfp_datapath.sv -----
// ----------------------------------------------------------------------------
// cfp_datapath: registers and arithmetic of the pitch filter
// Holds the filter state, CSRs, CORDIC, radix-16 divide by 1000 and a shared
// multiplier; the state steps only on controller commands, the CSRs on writes.
// ----------------------------------------------------------------------------
module cfp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [cfp_pkg::TIME_W-1:0]             req_now_ms,
   input  logic signed [cfp_pkg::ACCEL_W-1:0]     req_accel_y,
   input  logic signed [cfp_pkg::ACCEL_W-1:0]     req_accel_z,
   input  logic signed [cfp_pkg::GYRO_W-1:0]      req_gyro_x,
   input  logic                                   csr_write_en,
   input  logic [cfp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [cfp_pkg::CFG_W-1:0]              csr_write_data,
   input  cfp_pkg::cfp_cmd_type                   cmd,
   output cfp_pkg::cfp_status_type                status,
   output logic signed [cfp_pkg::PITCH_W-1:0]     rsp_pitch_deg
);

   localparam int XW = cfp_pkg::CORDIC_W;
   localparam logic signed [XW-1:0] Z_HALF =
      {{(XW-cfp_pkg::ROUND_SH){1'b0}}, 1'b1, {(cfp_pkg::ROUND_SH-1){1'b0}}};
   localparam logic [cfp_pkg::REM_W:0] DIVISOR_V = (cfp_pkg::REM_W+1)'(cfp_pkg::DIVISOR);
   localparam logic [cfp_pkg::ALPHA_W:0] ALPHA_ONE = {1'b1, {cfp_pkg::ALPHA_W{1'b0}}};

   // CSRs and filter state
   logic [cfp_pkg::CFG_W-1:0]   sample_time_ff, sample_time_in;
   logic [cfp_pkg::CFG_W-1:0]   alpha_ff, alpha_in;
   logic [cfp_pkg::TIME_W-1:0]  last_time_ff, last_time_in;
   logic                        started_ff, started_in;
   logic signed [cfp_pkg::PITCH_W-1:0] pitch_ff, pitch_in;

   // Captured request
   logic [cfp_pkg::TIME_W-1:0]          dt_ff;
   logic signed [cfp_pkg::ACCEL_W-1:0]  ay_ff, az_ff;
   logic signed [cfp_pkg::GYRO_W-1:0]   gx_ff;

   // Working registers
   logic signed [cfp_pkg::MPROD_W-1:0]  prod_ff, sum_ff;
   logic [cfp_pkg::DIV_PAD_W-1:0]       num_ff, num_in;
   logic [cfp_pkg::REM_W-1:0]           rem_ff, rem_in;
   logic signed [XW-1:0]                x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic                                zero_vec_ff;
   logic signed [cfp_pkg::PITCH_W-1:0]  gyro_p_ff, acc_p_ff, acc_p_in, gyro_p_in;
   logic signed [cfp_pkg::PITCH_W-1:0]  rsp_pitch_ff;

   logic [cfp_pkg::TIME_W-1:0] dt_now;
   logic [cfp_pkg::MAG_W-1:0]  mag;

   assign dt_now       = req_now_ms - last_time_ff;
   assign status.started = started_ff;
   assign status.dt_ok   = (dt_now >= {{(cfp_pkg::TIME_W-cfp_pkg::CFG_W){1'b0}}, sample_time_ff});
   assign mag = gx_ff[cfp_pkg::GYRO_W-1] ? (~gx_ff + 1'b1) : gx_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;

   // Configuration and state updates
   always_comb begin
      sample_time_in = sample_time_ff;
      alpha_in       = alpha_ff;
      if (csr_write_en) begin
         if (csr_index == cfp_pkg::CSR_SAMPLE_TIME) begin
            sample_time_in = csr_write_data;
         end else if (csr_index == cfp_pkg::CSR_BLEND_ALPHA) begin
            alpha_in = csr_write_data;
         end
      end
      last_time_in = last_time_ff;
      started_in   = started_ff;
      if (cmd.take && cmd.take_upd) begin
         last_time_in = req_now_ms;
         started_in   = 1'b1;
      end
   end

   // Shared multiplier
   logic signed [cfp_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [cfp_pkg::MPROD_W-1:0] mul_p;
   logic [cfp_pkg::ALPHA_W:0]          beta;

   always_comb begin
      beta = ALPHA_ONE - {1'b0, alpha_ff};
      unique case (cmd.mul_sel)
         cfp_pkg::MUL_SEL_DT: begin
            mul_a = {{(cfp_pkg::MUL_W-cfp_pkg::MAG_W){1'b0}}, mag};
            mul_b = {1'b0, dt_ff};
         end
         cfp_pkg::MUL_SEL_ALPHA: begin
            mul_a = {{(cfp_pkg::MUL_W-cfp_pkg::ALPHA_W){1'b0}}, alpha_ff};
            mul_b = {gyro_p_ff[cfp_pkg::PITCH_W-1], gyro_p_ff};
         end
         cfp_pkg::MUL_SEL_BETA: begin
            mul_a = {{(cfp_pkg::MUL_W-cfp_pkg::ALPHA_W-1){1'b0}}, beta};
            mul_b = {acc_p_ff[cfp_pkg::PITCH_W-1], acc_p_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // CORDIC init/step and divider init/step
   logic signed [XW-1:0]   x0, y0, xs, ys;
   logic [ATAN_IDX_W_L-1:0] k;
   localparam int ATAN_IDX_W_L = cfp_pkg::ATAN_IDX_W;
   logic signed [XW-1:0]   t_ext;
   logic                   cordic_on, div_on;
   logic [cfp_pkg::REM_W:0] r2;
   logic [cfp_pkg::DIV_PAD_W-1:0] num_v;
   logic [cfp_pkg::REM_W-1:0]     rem_v;

   always_comb begin
      x0 = {{(XW-cfp_pkg::ACCEL_W){az_ff[cfp_pkg::ACCEL_W-1]}}, az_ff} <<< cfp_pkg::ACC_SHIFT;
      y0 = -({{(XW-cfp_pkg::ACCEL_W){ay_ff[cfp_pkg::ACCEL_W-1]}}, ay_ff} <<< cfp_pkg::ACC_SHIFT);
      k  = ATAN_IDX_W_L'(cmd.iter_idx);
      xs = x_ff >>> k;
      ys = y_ff >>> k;
      t_ext = {{(XW-cfp_pkg::ATAN_W){1'b0}}, cfp_pkg::atan_q24(k)};
      cordic_on = ({1'b0, cmd.iter_idx} < (cfp_pkg::ITER_IDX_W+1)'(cfp_pkg::CORDIC_STEPS));
      div_on    = ({1'b0, cmd.iter_idx} < (cfp_pkg::ITER_IDX_W+1)'(cfp_pkg::DIV_CYCLES));

      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      num_v = num_ff;
      rem_v = rem_ff;
      r2 = '0;

      if (cmd.load) begin
         if (x0[XW-1]) begin
            // turn the vector by a half circle into the right half plane
            x_in = -x0;
            y_in = -y0;
            z_in = y0[XW-1] ? cfp_pkg::Z_MINUS_180 : cfp_pkg::Z_PLUS_180;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
         num_in = ({{(cfp_pkg::DIV_PAD_W-cfp_pkg::PROD_W){1'b0}},
                    prod_ff[cfp_pkg::PROD_W-1:0]} << cfp_pkg::GSH)
                  + cfp_pkg::DIV_PAD_W'(cfp_pkg::ROUND_ADD);
         rem_in = '0;
      end else if (cmd.iter_en) begin
         if (cordic_on) begin
            if (!y_ff[XW-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + t_ext;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - t_ext;
            end
         end
         if (div_on) begin
            // four restoring steps, quotient bits shift in at the bottom
            for (int j = 0; j < cfp_pkg::DIV_BITS; j++) begin
               r2    = {rem_v, num_v[cfp_pkg::DIV_PAD_W-1]};
               num_v = num_v << 1;
               if (r2 >= DIVISOR_V) begin
                  r2       = r2 - DIVISOR_V;
                  num_v[0] = 1'b1;
               end
               rem_v = r2[cfp_pkg::REM_W-1:0];
            end
            num_in = num_v;
            rem_in = rem_v;
         end
      end
   end

   // Finish: round the angle, apply the gyro step
   logic signed [XW-1:0]                z_rnd;
   logic signed [cfp_pkg::GSTEP_W-1:0]  step_mag, step_s, pe_ext, gdiff;

   always_comb begin
      z_rnd = (z_ff + Z_HALF) >>> cfp_pkg::ROUND_SH;
      acc_p_in = zero_vec_ff ? '0 :
                 cfp_pkg::sat_pitch({{(cfp_pkg::SAT_W-XW){z_rnd[XW-1]}}, z_rnd});
      step_mag = {2'b00, num_ff};
      step_s   = gx_ff[cfp_pkg::GYRO_W-1] ? -step_mag : step_mag;
      pe_ext   = {{(cfp_pkg::GSTEP_W-cfp_pkg::PITCH_W){pitch_ff[cfp_pkg::PITCH_W-1]}}, pitch_ff};
      gdiff    = pe_ext - step_s;
      gyro_p_in = cfp_pkg::sat_pitch(
                     {{(cfp_pkg::SAT_W-cfp_pkg::GSTEP_W){gdiff[cfp_pkg::GSTEP_W-1]}}, gdiff});
   end

   // Blend
   logic signed [cfp_pkg::BLEND_W-1:0] mix, mix_sh;

   always_comb begin
      mix = {{(cfp_pkg::BLEND_W-cfp_pkg::MPROD_W){sum_ff[cfp_pkg::MPROD_W-1]}}, sum_ff}
          + {{(cfp_pkg::BLEND_W-cfp_pkg::MPROD_W){prod_ff[cfp_pkg::MPROD_W-1]}}, prod_ff}
          + (cfp_pkg::BLEND_W)'(1 << (cfp_pkg::ALPHA_W-1));
      mix_sh = mix >>> cfp_pkg::ALPHA_W;
      pitch_in = pitch_ff;
      if (cmd.finish && cmd.first) begin
         pitch_in = acc_p_in;
      end else if (cmd.blend) begin
         pitch_in = cfp_pkg::sat_pitch(
                       {{(cfp_pkg::SAT_W-cfp_pkg::BLEND_W){mix_sh[cfp_pkg::BLEND_W-1]}}, mix_sh});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_time_ff <= cfp_pkg::SAMPLE_TIME_RESET;
         alpha_ff       <= cfp_pkg::BLEND_ALPHA_RESET;
         last_time_ff   <= '0;
         started_ff     <= 1'b0;
         pitch_ff       <= '0;
      end else begin
         sample_time_ff <= sample_time_in;
         alpha_ff       <= alpha_in;
         last_time_ff   <= last_time_in;
         started_ff     <= started_in;
         pitch_ff       <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         dt_ff <= dt_now;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
      end
      if (cmd.load) begin
         zero_vec_ff <= (ay_ff == '0) && (az_ff == '0);
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.sum_cap) begin
         sum_ff <= prod_ff;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (cmd.finish) begin
         acc_p_ff  <= acc_p_in;
         gyro_p_ff <= gyro_p_in;
      end
      if (cmd.out_load) begin
         rsp_pitch_ff <= pitch_ff;
      end
   end

endmodule

// ----- design/cfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfp_ctrl: sequencer of the pitch filter
// Steps a request through multiply, CORDIC/divide, blend, output; an early one skips to output, the first skips blend.
// ----------------------------------------------------------------------------
module cfp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_updated,
   input  cfp_pkg::cfp_status_type status,
   output cfp_pkg::cfp_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MULDT  = 4'd1;
   localparam logic [3:0] ST_LOAD   = 4'd2;
   localparam logic [3:0] ST_ITER   = 4'd3;
   localparam logic [3:0] ST_FINISH = 4'd4;
   localparam logic [3:0] ST_MULA   = 4'd5;
   localparam logic [3:0] ST_MULB   = 4'd6;
   localparam logic [3:0] ST_BLEND  = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   localparam logic [cfp_pkg::ITER_IDX_W-1:0] IDX_LAST =
      cfp_pkg::ITER_IDX_W'(cfp_pkg::ITER_CYCLES - 1);

   logic [3:0]                     state_ff, state_in;
   logic [cfp_pkg::ITER_IDX_W-1:0] idx_ff, idx_in;
   logic first_ff, first_in, upd_ff, upd_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_updated_ff, rsp_updated_in;
   logic accept;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_updated = rsp_updated_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      first_in       = first_ff;
      upd_in         = upd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_updated_in = rsp_updated_ff;
      cmd            = '0;
      cmd.mul_sel    = cfp_pkg::MUL_SEL_DT;
      cmd.iter_idx   = idx_ff;
      cmd.first      = first_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.take     = 1'b1;
               cmd.take_upd = !status.started || status.dt_ok;
               first_in     = !status.started;
               upd_in       = cmd.take_upd;
               state_in     = cmd.take_upd ? ST_MULDT : ST_OUT;
            end
         end
         ST_MULDT: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            idx_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter_en = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == IDX_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = first_ff ? ST_OUT : ST_MULA;
         end
         ST_MULA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cfp_pkg::MUL_SEL_ALPHA;
            state_in    = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cfp_pkg::MUL_SEL_BETA;
            cmd.sum_cap = 1'b1;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load   = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_updated_in = upd_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         first_ff     <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_updated_ff <= rsp_updated_in;
   end

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result register overwritten while stalled");

   a_drop_skips: assert property (@(posedge clock) disable iff (reset)
      (accept && status.started && !status.dt_ok) |=> (state_ff == ST_OUT && !upd_ff))
      else $error("early request not dropped");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside output state");

   a_iter_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && idx_ff == IDX_LAST) |=> (state_ff == ST_FINISH))
      else $error("iteration phase did not end on last index");

endmodule

// ----- design/complementary_filter_pitch.sv -----
// ----------------------------------------------------------------------------
// complementary_filter_pitch: IMU pitch estimate from accel and gyro
// Blends integrated gyro rate with the accelerometer tilt angle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (req_*) carry a millisecond timestamp, accel Y/Z and gyro X rate
//   and are taken when req_valid and req_ready are high. Every request yields
//   one response (rsp_*): rsp_updated tells whether the pitch moved, and
//   rsp_pitch_deg is the current pitch in Q16 degrees.
//   An updating request goes from accept to the output register through one
//   multiply, a load step, 16 iterations in which the CORDIC and the
//   radix-16 divide by 1000 run side by side, a finish step, the alpha and
//   beta products on the shared multiplier and the blend. An early request
//   goes straight to the output register; the first request after reset
//   skips the products and the blend. req_ready is high only between
//   requests, so a new request is taken only after the last one reaches the
//   output register. A finished response sits there; the next request is
//   taken meanwhile, and its result waits if the receiver still stalls.
//   Reset restores the CSRs (sample time 10 ms, alpha 64225) and clears the
//   pitch, last timestamp and started flag. The user must write CSRs through
//   csr_write_en/csr_index/csr_write_data while no request is in flight; the block does not check.
// ----------------------------------------------------------------------------
module complementary_filter_pitch (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cfp_pkg::TIME_W-1:0]         req_now_ms,
   input  logic signed [cfp_pkg::ACCEL_W-1:0] req_accel_y,
   input  logic signed [cfp_pkg::ACCEL_W-1:0] req_accel_z,
   input  logic signed [cfp_pkg::GYRO_W-1:0]  req_gyro_x,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_updated,
   output logic signed [cfp_pkg::PITCH_W-1:0] rsp_pitch_deg,
   input  logic                               csr_write_en,
   input  logic [cfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cfp_pkg::CFG_W-1:0]          csr_write_data
);

   cfp_pkg::cfp_cmd_type    cmd;
   cfp_pkg::cfp_status_type status;

   cfp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_updated (rsp_updated),
      .status      (status),
      .cmd         (cmd)
   );

   cfp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_now_ms     (req_now_ms),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .req_gyro_x     (req_gyro_x),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_pitch_deg  (rsp_pitch_deg)
   );

endmodule
